[design/cse_pkg.sv]
// Shared types, constants and helpers for the C string escape encoder.
// No dependencies; used by every module of the block.
package cse_pkg;

    localparam int CHAR_BITS = 16;
    localparam int ESC_BITS  = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Request kinds handed from the classifier to the emitter.
    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_HEX   = 2'd2;

    // Output positions within one escaped request.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_HIGH   = 2'd2;
    localparam logic [1:0] POS_LOW    = 2'd3;

    localparam logic [ESC_BITS-1:0] CH_BSLASH = 8'h5c;
    localparam logic [ESC_BITS-1:0] CH_X      = 8'h78;
    localparam logic [ESC_BITS-1:0] CH_SQUOTE = 8'h27;
    localparam logic [ESC_BITS-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_BITS-1:0] CTRL_LIMIT = 16'h0020;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CHAR_BITS-1:0] chr;
        logic [ESC_BITS-1:0]  esc;
    } cmd_t;

    // Upper-case ASCII hex digit for a nibble.
    function automatic logic [ESC_BITS-1:0] hex_digit(input logic [3:0] nib);
        logic [ESC_BITS-1:0] d;
        begin
            if (nib < 4'd10)
                d = 8'h30 + {4'd0, nib};
            else
                d = 8'h37 + {4'd0, nib};
            return d;
        end
    endfunction

endpackage

[design/c_string_escape_encoder.sv]
// Top level of the C string escape encoder.
// Depends on cse_pkg, cse_classify, cse_queue and cse_emit.
//
// Usage:
//   Slave stream: one 16-bit character per request on s_tdata; s_tuser high
//   marks the first character of a string and clears the hex-escape flag.
//   Master stream: one output character per request on m_tdata; m_tlast is
//   high on the final character produced for an input character.
//   Each input expands to 1 (plain), 2 (\n, \\, ...) or 4 (\xHH) characters.
//   Path: queue, then emitter request register cur_reg, then output register.
//   Throughput: the emitter produces one output character per cycle while
//   m_tready is high, so an input occupies the output for 1, 2 or 4 characters; up to 4 classified
//   requests buffer in the queue, so input is taken back to back while the
//   queue has room.
//   Reset (aresetn low, synchronous): queue emptied, output invalid, the
//   hex-escape flag cleared.
//   Stall: when m_tready is low the output register holds, the emitter waits,
//   and the queue fills; s_tready drops only once the queue is full.
module c_string_escape_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cse_pkg::CHAR_BITS-1:0] s_tdata,   // [15:0] in_char
    input  logic                          s_tuser,   // [0] start_of_string
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cse_pkg::CHAR_BITS-1:0] m_tdata,   // [15:0] out_char
    output logic                          m_tlast    // last_of_run
);

    cse_pkg::cmd_t front_cmd;
    cse_pkg::cmd_t q_head;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    cse_classify u_classify (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .in_char         (s_tdata),
        .start_of_string (s_tuser),
        .cmd             (front_cmd)
    );

    cse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    cse_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An escape sequence is emitted without gaps once its first character goes out.
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("escape run broken by an idle cycle");

    // Output is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A request is never popped from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue underflow");

endmodule

[design/cse_classify.sv]
// Front end: classifies each accepted character and tracks the hex-escape flag.
// Depends on cse_pkg.
module cse_classify (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [cse_pkg::CHAR_BITS-1:0] in_char,
    input  logic                          start_of_string,
    output cse_pkg::cmd_t                 cmd
);

    logic after_hex_reg;
    logic after_hex_next;
    logic flag_eff;
    logic is_hex;
    logic [cse_pkg::ESC_BITS-1:0] esc;

    assign flag_eff = after_hex_reg & ~start_of_string;

    assign is_hex = (in_char >= 16'h0030 && in_char <= 16'h0039) ||
                    (in_char >= 16'h0061 && in_char <= 16'h0066) ||
                    (in_char >= 16'h0041 && in_char <= 16'h0046);

    always_comb begin
        unique case (in_char)
            16'h0007: esc = 8'h61;   // a
            16'h0008: esc = 8'h62;   // b
            16'h000c: esc = 8'h66;   // f
            16'h000a: esc = 8'h6e;   // n
            16'h000d: esc = 8'h72;   // r
            16'h0009: esc = 8'h74;   // t
            16'h000b: esc = 8'h76;   // v
            16'h005c: esc = cse_pkg::CH_BSLASH;
            16'h0027: esc = cse_pkg::CH_SQUOTE;
            16'h0022: esc = cse_pkg::CH_DQUOTE;
            default:  esc = 8'h00;
        endcase
    end

    always_comb begin
        cmd.chr = in_char;
        cmd.esc = esc;
        if (esc != 8'h00)
            cmd.kind = cse_pkg::KIND_SHORT;
        else if (in_char < cse_pkg::CTRL_LIMIT || (flag_eff && is_hex))
            cmd.kind = cse_pkg::KIND_HEX;
        else
            cmd.kind = cse_pkg::KIND_PASS;
    end

    assign after_hex_next = push ? (cmd.kind == cse_pkg::KIND_HEX) : after_hex_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            after_hex_reg <= 1'b0;
        else
            after_hex_reg <= after_hex_next;
    end

endmodule

[design/cse_queue.sv]
// Small FIFO of classified requests between front and back end.
// Depends on cse_pkg.
module cse_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cse_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output cse_pkg::cmd_t head
);

    cse_pkg::cmd_t mem [cse_pkg::Q_DEPTH];
    logic [cse_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cse_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cse_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == cse_pkg::Q_CNT_W'(cse_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/cse_emit.sv]
// Back end: expands one request into one, two or four output characters.
// Depends on cse_pkg; drives the output register of the result stream.
module cse_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  cse_pkg::cmd_t                 q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cse_pkg::CHAR_BITS-1:0] m_tdata,
    output logic                          m_tlast
);

    cse_pkg::cmd_t cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    pos_reg, pos_next;
    logic          m_valid_reg, m_valid_next;
    logic [cse_pkg::CHAR_BITS-1:0] m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    logic          out_free;
    logic          emit;
    logic          is_last;
    logic [cse_pkg::CHAR_BITS-1:0] chr_out;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = cur_valid_reg && out_free;

    always_comb begin
        chr_out = '0;
        unique case (pos_reg)
            cse_pkg::POS_FIRST:
                chr_out = (cur_reg.kind == cse_pkg::KIND_PASS) ? cur_reg.chr :
                          cse_pkg::CHAR_BITS'(cse_pkg::CH_BSLASH);
            cse_pkg::POS_SECOND:
                chr_out = (cur_reg.kind == cse_pkg::KIND_HEX) ?
                          cse_pkg::CHAR_BITS'(cse_pkg::CH_X) :
                          cse_pkg::CHAR_BITS'(cur_reg.esc);
            cse_pkg::POS_HIGH:
                chr_out = cse_pkg::CHAR_BITS'(cse_pkg::hex_digit(cur_reg.chr[7:4]));
            cse_pkg::POS_LOW:
                chr_out = cse_pkg::CHAR_BITS'(cse_pkg::hex_digit(cur_reg.chr[3:0]));
            default: chr_out = '0;
        endcase
    end

    assign is_last = (cur_reg.kind == cse_pkg::KIND_PASS  && pos_reg == cse_pkg::POS_FIRST) ||
                     (cur_reg.kind == cse_pkg::KIND_SHORT && pos_reg == cse_pkg::POS_SECOND) ||
                     (pos_reg == cse_pkg::POS_LOW);

    // Fetch a new request when idle or when the current one finishes this cycle.
    assign q_pop = !q_empty && (!cur_valid_reg || (emit && is_last));

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = chr_out;
            m_last_next  = is_last;
            pos_next     = pos_reg + 1'b1;
            if (is_last)
                cur_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            pos_next       = cse_pkg::POS_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= cse_pkg::POS_FIRST;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
